[src/rarmt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package rarmt_pkg;

  localparam int DATA_W = 32;
  localparam int LC_W   = 11;
  localparam int IDX_W  = 10;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [LC_W-1:0]   LC_RESET = LC_W'(1024);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_VISIT,
    ST_FULL_RD,
    ST_FULL_WR,
    ST_RET,
    ST_FA0,
    ST_FA1,
    ST_FA2,
    ST_FQ0,
    ST_FQ1,
    ST_EMIT
  } state_t;

  function automatic logic [DATA_W-1:0] smax(input logic [DATA_W-1:0] a,
                                             input logic [DATA_W-1:0] b);
    return ($signed(a) > $signed(b)) ? a : b;
  endfunction

endpackage
`default_nettype wire

[src/rarmt_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface rarmt_item_if;
  logic                            valid;
  logic                            ready;
  logic                            mode;
  logic [rarmt_pkg::IDX_W-1:0]     range_low;
  logic [rarmt_pkg::IDX_W-1:0]     range_high;
  logic signed [rarmt_pkg::DATA_W-1:0] add_amount;
  modport source (output valid, mode, range_low, range_high, add_amount, input ready);
  modport sink (input valid, mode, range_low, range_high, add_amount, output ready);
endinterface

interface rarmt_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [rarmt_pkg::DATA_W-1:0] max_value;
  logic                                range_error;
  modport source (output valid, max_value, range_error, input ready);
  modport sink (input valid, max_value, range_error, output ready);
endinterface

interface rarmt_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [rarmt_pkg::LC_W-1:0]   leaf_count;
  modport source (output valid, leaf_count, input ready);
  modport sink (input valid, leaf_count, output ready);
endinterface
`default_nettype wire

[src/rarmt_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module rarmt_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [AW-1:0]                 addr,
  input  wire logic [rarmt_pkg::DATA_W-1:0]  wdata,
  output logic      [rarmt_pkg::DATA_W-1:0]  rdata
);

  logic [rarmt_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

[src/rarmt_walk.sv]
`timescale 1ns / 1ps
`default_nettype none
module rarmt_walk #(
  parameter int MAX_LEAVES = 1024
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic [rarmt_pkg::LC_W-1:0]            leaf_count,
  rarmt_item_if.sink                                 item,
  input  wire logic                                  slot_free,
  output logic                                       res_push,
  output logic [rarmt_pkg::DATA_W-1:0]               res_max,
  output logic                                       res_err,
  output logic [$clog2(MAX_LEAVES)+1:0]              ram_addr,
  output logic                                       max_we,
  output logic                                       pend_we,
  output logic [rarmt_pkg::DATA_W-1:0]               max_wd,
  output logic [rarmt_pkg::DATA_W-1:0]               pend_wd,
  input  wire logic [rarmt_pkg::DATA_W-1:0]          max_rd,
  input  wire logic [rarmt_pkg::DATA_W-1:0]          pend_rd
);

  localparam int AW  = $clog2(MAX_LEAVES) + 2;
  localparam int NB  = $clog2(MAX_LEAVES) + 1;
  localparam int VW  = (NB > rarmt_pkg::LC_W) ? NB : rarmt_pkg::LC_W;
  localparam int SD  = $clog2(MAX_LEAVES) + 1;
  localparam int IW  = $clog2(SD);
  localparam int SPW = $clog2(SD + 1);
  localparam int DW  = rarmt_pkg::DATA_W;

  rarmt_pkg::state_t state, state_next;

  logic [AW-1:0]  clr;
  logic           mode_q;
  logic [VW-1:0]  ql, qr, l, r;
  logic [DW-1:0]  amt, best, ret, tmp;
  logic           err;
  logic [AW-1:0]  k;
  logic [SPW-1:0] sp;

  logic [AW-1:0]  sk    [SD];
  logic [VW-1:0]  sl    [SD];
  logic [VW-1:0]  sr    [SD];
  logic           sside [SD];
  logic [DW-1:0]  sbest [SD];

  logic [VW-1:0]  lc_ext, n, lo_ext, hi_ext, m, t_m;
  logic [VW:0]    lr_sum, t_sum;
  logic           bad, full, descend;
  logic [SPW-1:0] spm1;
  logic [IW-1:0]  tp, pi;
  logic [DW-1:0]  node_val, q_best;
  logic [AW-1:0]  child_l, child_r;

  // effective leaf count: zero reads as one, saturate at the tree size
  always_comb begin
    lc_ext = VW'(leaf_count);
    if (lc_ext == '0) begin
      n = VW'(1);
    end else if (lc_ext > VW'(MAX_LEAVES)) begin
      n = VW'(MAX_LEAVES);
    end else begin
      n = lc_ext;
    end
  end

  assign lo_ext   = VW'(item.range_low);
  assign hi_ext   = VW'(item.range_high);
  assign bad      = (lo_ext > hi_ext) || (hi_ext >= n);
  assign lr_sum   = {1'b0, l} + {1'b0, r};
  assign m        = lr_sum[VW:1];
  assign full     = (ql <= l) && (r <= qr);
  assign child_l  = {k[AW-2:0], 1'b0};
  assign child_r  = {k[AW-2:0], 1'b1};
  assign node_val = max_rd + pend_rd;
  assign spm1     = sp - 1'b1;
  assign tp       = spm1[IW-1:0];
  assign pi       = sp[IW-1:0];
  assign t_sum    = {1'b0, sl[tp]} + {1'b0, sr[tp]};
  assign t_m      = t_sum[VW:1];
  assign descend  = !sside[tp] && (qr > t_m);
  assign q_best   = (mode_q == rarmt_pkg::MODE_QUERY) ? rarmt_pkg::smax(sbest[tp], ret)
                                                      : sbest[tp];

  always_comb begin
    state_next = state;
    case (state)
      rarmt_pkg::ST_CLEAR: begin
        if (clr == {AW{1'b1}}) state_next = rarmt_pkg::ST_IDLE;
      end
      rarmt_pkg::ST_IDLE: begin
        if (item.valid) begin
          if (!bad) state_next = rarmt_pkg::ST_VISIT;
          else if (item.mode == rarmt_pkg::MODE_QUERY) state_next = rarmt_pkg::ST_EMIT;
        end
      end
      rarmt_pkg::ST_VISIT: begin
        if (full) state_next = rarmt_pkg::ST_FULL_RD;
      end
      rarmt_pkg::ST_FULL_RD: state_next = rarmt_pkg::ST_FULL_WR;
      rarmt_pkg::ST_FULL_WR: state_next = rarmt_pkg::ST_RET;
      rarmt_pkg::ST_RET: begin
        if (sp == '0) begin
          state_next = (mode_q == rarmt_pkg::MODE_QUERY) ? rarmt_pkg::ST_EMIT
                                                         : rarmt_pkg::ST_IDLE;
        end else if (descend) begin
          state_next = rarmt_pkg::ST_VISIT;
        end else begin
          state_next = (mode_q == rarmt_pkg::MODE_QUERY) ? rarmt_pkg::ST_FQ0
                                                         : rarmt_pkg::ST_FA0;
        end
      end
      rarmt_pkg::ST_FA0: state_next = rarmt_pkg::ST_FA1;
      rarmt_pkg::ST_FA1: state_next = rarmt_pkg::ST_FA2;
      rarmt_pkg::ST_FA2: state_next = rarmt_pkg::ST_RET;
      rarmt_pkg::ST_FQ0: state_next = rarmt_pkg::ST_FQ1;
      rarmt_pkg::ST_FQ1: state_next = rarmt_pkg::ST_RET;
      rarmt_pkg::ST_EMIT: begin
        if (slot_free) state_next = rarmt_pkg::ST_IDLE;
      end
      default: state_next = rarmt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    item.ready = (state == rarmt_pkg::ST_IDLE);
    res_push   = (state == rarmt_pkg::ST_EMIT) && slot_free;
    res_max    = ret;
    res_err    = err;
    ram_addr   = k;
    max_we     = 1'b0;
    pend_we    = 1'b0;
    max_wd     = rarmt_pkg::smax(tmp, node_val);
    pend_wd    = pend_rd + amt;
    case (state)
      rarmt_pkg::ST_CLEAR: begin
        ram_addr = clr;
        max_we   = 1'b1;
        pend_we  = 1'b1;
        max_wd   = '0;
        pend_wd  = '0;
      end
      rarmt_pkg::ST_FULL_WR: pend_we = (mode_q == rarmt_pkg::MODE_ADD);
      rarmt_pkg::ST_FA0: ram_addr = child_l;
      rarmt_pkg::ST_FA1: ram_addr = child_r;
      rarmt_pkg::ST_FA2: max_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rarmt_pkg::ST_CLEAR;
      clr   <= '0;
    end else begin
      state <= state_next;
      if (state == rarmt_pkg::ST_CLEAR) clr <= clr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      rarmt_pkg::ST_IDLE: begin
        if (item.valid) begin
          mode_q <= item.mode;
          ql     <= lo_ext;
          qr     <= hi_ext;
          amt    <= item.add_amount;
          k      <= AW'(1);
          l      <= '0;
          r      <= n - 1'b1;
          sp     <= '0;
          ret    <= '0;
          err    <= bad;
        end
      end
      rarmt_pkg::ST_VISIT: begin
        if (!full) begin
          // push the partly covered node, step into its first overlapping child
          sk[pi]    <= k;
          sl[pi]    <= l;
          sr[pi]    <= r;
          sbest[pi] <= rarmt_pkg::MIN_VAL;
          sside[pi] <= !(ql <= m);
          sp        <= sp + 1'b1;
          if (ql <= m) begin
            k <= child_l;
            r <= m;
          end else begin
            k <= child_r;
            l <= m + 1'b1;
          end
        end
      end
      rarmt_pkg::ST_FULL_WR: begin
        if (mode_q == rarmt_pkg::MODE_QUERY) ret <= node_val;
      end
      rarmt_pkg::ST_RET: begin
        if (sp != '0) begin
          if (descend) begin
            sside[tp] <= 1'b1;
            sbest[tp] <= q_best;
            k         <= {sk[tp][AW-2:0], 1'b1};
            l         <= t_m + 1'b1;
            r         <= sr[tp];
          end else begin
            k    <= sk[tp];
            l    <= sl[tp];
            r    <= sr[tp];
            best <= q_best;
            sp   <= spm1;
          end
        end
      end
      rarmt_pkg::ST_FA1: tmp <= node_val;
      rarmt_pkg::ST_FQ1: ret <= best + pend_rd;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[src/range_add_range_max_tree.sv]
`timescale 1ns / 1ps
`default_nettype none
// Segment tree with lazy range add and range maximum over up to MAX_LEAVES
// signed 32-bit elements, all sums wrapping at 32 bits. Node maxima and
// pending adds sit in two single-port RAMs of 4*MAX_LEAVES words each,
// walked depth first by one sequencer with a small register stack. The cost
// of an item is set by the nodes it touches, one RAM access per cycle with
// registered read data: a fully covered node is read, then has its pending
// add written for an add or its value captured for a query. A partly
// covered node is pushed on the stack, its overlapping children are walked,
// and on return a query folds in its pending add while an add reads both
// children and writes back their maximum. Items are taken one at a time; a
// query result waits in an output register while the next item is accepted.
// After reset the RAMs are cleared, during which no item is accepted;
// leaf_count writes are always taken. A query over an empty range or one
// past leaf_count returns range_error with max_value 0; such an add is
// dropped and returns nothing.
module range_add_range_max_tree #(
  parameter int MAX_LEAVES = 1024
) (
  input wire logic    clk,
  input wire logic    rst,
  rarmt_cfg_if.sink   cfg,
  rarmt_item_if.sink  item,
  rarmt_res_if.source result
);

  localparam int AW    = $clog2(MAX_LEAVES) + 2;
  localparam int DEPTH = 4 * MAX_LEAVES;

  logic [rarmt_pkg::LC_W-1:0]   leaf_count;
  logic                         res_valid;
  logic [rarmt_pkg::DATA_W-1:0] res_max_q;
  logic                         res_err_q;
  logic                         slot_free;
  logic                         res_push;
  logic [rarmt_pkg::DATA_W-1:0] res_max;
  logic                         res_err;
  logic [AW-1:0]                ram_addr;
  logic                         max_we, pend_we;
  logic [rarmt_pkg::DATA_W-1:0] max_wd, pend_wd, max_rd, pend_rd;

  // config: always ready; the tree shape is sampled when an item is accepted
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      leaf_count <= rarmt_pkg::LC_RESET;
    end else if (cfg.valid) begin
      leaf_count <= cfg.leaf_count;
    end
  end

  // result register: hold a beat until taken, refill in the same cycle
  assign slot_free = !res_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_push) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_max_q <= res_max;
      res_err_q <= res_err;
    end
  end

  assign result.valid       = res_valid;
  assign result.max_value   = res_max_q;
  assign result.range_error = res_err_q;

  // tree walker: clear pass, descent, and read-modify-write of nodes
  rarmt_walk #(
    .MAX_LEAVES (MAX_LEAVES)
  ) u_walk (
    .clk        (clk),
    .rst        (rst),
    .leaf_count (leaf_count),
    .item       (item),
    .slot_free  (slot_free),
    .res_push   (res_push),
    .res_max    (res_max),
    .res_err    (res_err),
    .ram_addr   (ram_addr),
    .max_we     (max_we),
    .pend_we    (pend_we),
    .max_wd     (max_wd),
    .pend_wd    (pend_wd),
    .max_rd     (max_rd),
    .pend_rd    (pend_rd)
  );

  // subtree maxima, excluding each node's own pending add
  rarmt_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_max_ram (
    .clk   (clk),
    .we    (max_we),
    .addr  (ram_addr),
    .wdata (max_wd),
    .rdata (max_rd)
  );

  // pending adds, applied to the node's whole span
  rarmt_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_pend_ram (
    .clk   (clk),
    .we    (pend_we),
    .addr  (ram_addr),
    .wdata (pend_wd),
    .rdata (pend_rd)
  );

endmodule
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;

  localparam int LEAVES_MAX = 1024;
  localparam int SLOTS = 4 * LEAVES_MAX;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rarmt_cfg_if  cfg_ch();
  rarmt_item_if item_ch();
  rarmt_res_if  res_ch();

  range_add_range_max_tree #(.MAX_LEAVES(LEAVES_MAX)) dut (
    .clk(clk), .rst(rst), .cfg(cfg_ch.sink), .item(item_ch.sink), .result(res_ch.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the tree: subtree maxima and pending adds per node slot.
  logic [rarmt_pkg::DATA_W-1:0] tree_max [SLOTS];
  logic [rarmt_pkg::DATA_W-1:0] tree_pend [SLOTS];
  logic [rarmt_pkg::LC_W-1:0]   shadow_leaves;

  typedef struct packed {
    logic [rarmt_pkg::DATA_W-1:0] max_value;
    logic                         range_error;
  } max_result_t;

  max_result_t pending_maxima[$];
  int  failures = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  recv_hold_cycles = 0;

  function automatic logic [rarmt_pkg::DATA_W-1:0] signed_max(
      logic [rarmt_pkg::DATA_W-1:0] a, logic [rarmt_pkg::DATA_W-1:0] b);
    return ($signed(a) > $signed(b)) ? a : b;
  endfunction

  function automatic int live_leaves();
    int n;
    n = shadow_leaves;
    if (n == 0) n = 1;
    if (n > LEAVES_MAX) n = LEAVES_MAX;
    return n;
  endfunction

  function automatic void tree_range_add(int k, int l, int r, int ql, int qr,
                                         logic [rarmt_pkg::DATA_W-1:0] v);
    int m;
    if (k >= SLOTS || qr < l || ql > r) return;
    if (ql <= l && r <= qr) begin
      tree_pend[k] += v;
      return;
    end
    if (2 * k + 1 >= SLOTS) return;
    m = (l + r) / 2;
    tree_range_add(2 * k, l, m, ql, qr, v);
    tree_range_add(2 * k + 1, m + 1, r, ql, qr, v);
    tree_max[k] = signed_max(tree_max[2 * k] + tree_pend[2 * k],
                             tree_max[2 * k + 1] + tree_pend[2 * k + 1]);
  endfunction

  function automatic logic [rarmt_pkg::DATA_W-1:0] tree_range_max(int k, int l, int r,
                                                                  int ql, int qr);
    logic [rarmt_pkg::DATA_W-1:0] best;
    int m;
    best = rarmt_pkg::MIN_VAL;
    if (k >= SLOTS) return best;
    if (ql <= l && r <= qr) return tree_max[k] + tree_pend[k];
    if (2 * k + 1 >= SLOTS) return best;
    m = (l + r) / 2;
    if (ql <= m) best = signed_max(best, tree_range_max(2 * k, l, m, ql, qr));
    if (qr > m) best = signed_max(best, tree_range_max(2 * k + 1, m + 1, r, ql, qr));
    return best + tree_pend[k];
  endfunction

  // Update the shadow tree for one accepted beat, queue a result for a query.
  function automatic void predict_item(logic mode, int lo, int hi,
                                       logic [rarmt_pkg::DATA_W-1:0] amt);
    int n;
    bit bad;
    max_result_t r;
    n = live_leaves();
    bad = (lo > hi) || (hi >= n);
    if (mode == rarmt_pkg::MODE_ADD) begin
      if (!bad) tree_range_add(1, 0, n - 1, lo, hi, amt);
      return;
    end
    r.range_error = bad;
    r.max_value = bad ? '0 : tree_range_max(1, 0, n - 1, lo, hi);
    pending_maxima.push_back(r);
  endfunction

  // Send one beat, with random idle cycles ahead of it per the sender rate.
  // Valid stays up after the beat is taken; the next idle cycle or drain drops it.
  task automatic send_item(logic mode, int lo, int hi, logic [rarmt_pkg::DATA_W-1:0] amt);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.mode       <= mode;
    item_ch.range_low  <= rarmt_pkg::IDX_W'(lo);
    item_ch.range_high <= rarmt_pkg::IDX_W'(hi);
    item_ch.add_amount <= amt;
    do @(posedge clk); while (!item_ch.ready);
    predict_item(mode, lo, hi, amt);
  endtask

  task automatic send_add(int lo, int hi, logic [rarmt_pkg::DATA_W-1:0] amt);
    send_item(rarmt_pkg::MODE_ADD, lo, hi, amt);
  endtask

  task automatic send_query(int lo, int hi);
    send_item(rarmt_pkg::MODE_QUERY, lo, hi, $urandom);
  endtask

  // Wait for the result queue to drain, then give any add still in flight time to finish.
  task automatic drain();
    item_ch.valid <= 1'b0;
    while (pending_maxima.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_leaf_count(int value);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.leaf_count <= rarmt_pkg::LC_W'(value);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid  <= 1'b0;
    shadow_leaves = rarmt_pkg::LC_W'(value);
  endtask

  // Random in-range or occasionally broken range, biased toward small spans.
  task automatic random_item();
    int n, lo, hi;
    n = live_leaves();
    lo = $urandom_range(n - 1);
    case ($urandom_range(9))
      0: hi = $urandom_range(1023);
      1: hi = lo;
      2: begin lo = $urandom_range(1023); hi = $urandom_range(1023); end
      default: hi = $urandom_range(n - 1, lo);
    endcase
    if ($urandom_range(1)) send_add(lo, hi, $urandom);
    else send_query(lo, hi);
  endtask

  task automatic test_directed();
    write_leaf_count(1024);
    send_query(0, 1023);
    send_add(0, 1023, 32'h7fff_ffff);
    send_add(5, 5, 32'h0000_0001);
    send_query(0, 1023);
    send_query(5, 5);
    send_add(0, 0, 32'h8000_0000);
    send_query(0, 0);
    send_query(0, 1);
    send_add(1023, 1023, 32'hffff_ffff);
    send_query(1023, 1023);
    send_query(1022, 1023);
    send_query(7, 3);
    send_add(7, 3, 32'h1234_5678);
    send_query(0, 1023);
    send_add(512, 1023, 32'h5555_aaaa);
    send_query(100, 900);
    send_query(1023, 0);
    drain();
    write_leaf_count(10);
    send_query(0, 9);
    send_query(0, 10);
    send_add(9, 1023, 32'h1);
    send_add(2, 9, 32'hfffffffe);
    send_query(2, 9);
    drain();
    write_leaf_count(1);
    send_query(0, 0);
    send_query(0, 1);
    drain();
    write_leaf_count(0);
    send_query(0, 0);
    send_add(0, 0, 32'h0000_0003);
    send_query(0, 0);
    drain();
    write_leaf_count(2047);
    send_query(0, 1023);
    drain();
  endtask

  task automatic test_random_phase(int send_pct, int recv_pct, int count);
    int leaves [5] = '{1024, 2, 37, 1000, 500};
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 70 == 0) begin
        drain();
        write_leaf_count($urandom_range(1) ? leaves[$urandom_range(4)]
                                           : $urandom_range(2047));
      end
      random_item();
    end
    drain();
  endtask

  // Hold the receiver off while queries keep coming, so the block backs up.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_hold_cycles = 600;
    for (int i = 0; i < 8; i++) send_query(0, live_leaves() - 1);
    drain();
  endtask

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.leaf_count = '0;
    item_ch.valid = 1'b0;
    item_ch.mode = rarmt_pkg::MODE_ADD;
    item_ch.range_low = '0;
    item_ch.range_high = '0;
    item_ch.add_amount = '0;
    res_ch.ready = 1'b0;
    shadow_leaves = rarmt_pkg::LC_RESET;
    for (int k = 0; k < SLOTS; k++) begin
      tree_max[k] = '0;
      tree_pend[k] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_phase(11, 60, 340);
    test_backpressure();
    test_random_phase(60, 11, 340);
    test_random_phase(0, 0, 340);
    repeat (200) @(posedge clk);
    if (failures == 0)
      $display("range_add_range_max_tree: match");
    else
      $display("range_add_range_max_tree: mismatch");
    $finish;
  end

  // Drive ready: a long hold when asked, otherwise random idling.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (recv_hold_cycles > 0) begin
      recv_hold_cycles <= recv_hold_cycles - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each accepted result beat with the oldest prediction.
  always @(posedge clk) begin
    max_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_maxima.size() == 0) begin
        failures++;
        $display("%0t: unexpected result max_value=%h range_error=%b", $time,
                 res_ch.max_value, res_ch.range_error);
      end else begin
        want = pending_maxima.pop_front();
        if (want.max_value !== res_ch.max_value ||
            want.range_error !== res_ch.range_error) begin
          failures++;
          $display("%0t: expected max_value=%h range_error=%b, got %h %b", $time,
                   want.max_value, want.range_error, res_ch.max_value,
                   res_ch.range_error);
        end
      end
    end
  end

  initial begin
    #60ms;
    $display("range_add_range_max_tree: mismatch");
    $finish;
  end
endmodule
